[rtl/btr_pkg.sv]
// ----------------------------------------------------------------------------
// btr_pkg
// Types and constants shared by the bus telegram receiver modules.
// ----------------------------------------------------------------------------
package btr_pkg;

	localparam int unsigned HdrBytes = 6;
	localparam int unsigned PosW     = 5;

	typedef enum logic [1:0] {
		ST_HEADER  = 2'd0,
		ST_PAYLOAD = 2'd1,
		ST_ACCEPT  = 2'd2,
		ST_LRCERR  = 2'd3
	} status_t;

	typedef struct packed {
		status_t     frame_status;
		logic [7:0]  payload_byte;
		logic [3:0]  payload_index;
		logic [7:0]  control_field;
		logic [15:0] source_address;
		logic [15:0] destination_address;
		logic [7:0]  info_field;
		logic [4:0]  payload_length;
	} result_t;

endpackage

[rtl/btr_frame_core.sv]
// ----------------------------------------------------------------------------
// btr_frame_core
// Telegram framing state, captured header fields and the running LRC.
// Computes the result for the offered byte and updates state on accept.
// ----------------------------------------------------------------------------
module btr_frame_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	output btr_pkg::result_t    result
);

	logic [btr_pkg::PosW-1:0] byte_position_q;
	logic [7:0]               running_xor_q;
	logic [7:0]               control_q;
	logic [15:0]              source_q;
	logic [15:0]              destination_q;
	logic [7:0]               info_q;

	logic [btr_pkg::PosW-1:0] pos;
	logic [btr_pkg::PosW-1:0] pos_next;
	logic [btr_pkg::PosW-1:0] payload_end;
	logic [btr_pkg::PosW-1:0] payload_off;
	logic [7:0]               xor_base;
	logic [7:0]               xor_next;
	logic [7:0]               control_d;
	logic [15:0]              source_d;
	logic [15:0]              destination_d;
	logic [7:0]               info_d;
	logic                     in_header;
	logic                     in_payload;

	always_comb begin
		pos         = frame_start ? '0 : byte_position_q;
		xor_base    = frame_start ? 8'h00 : running_xor_q;
		// First position past the payload, where the check byte sits.
		payload_end = btr_pkg::PosW'(btr_pkg::HdrBytes) + {1'b0, info_q[3:0]} + 5'd1;
		payload_off = pos - btr_pkg::PosW'(btr_pkg::HdrBytes);
		in_header   = pos < btr_pkg::PosW'(btr_pkg::HdrBytes);
		in_payload  = !in_header && (pos < payload_end);

		control_d     = control_q;
		source_d      = source_q;
		destination_d = destination_q;
		info_d        = info_q;
		if (in_header) begin
			unique case (pos[2:0])
				3'd0: control_d = rx_byte;
				3'd1: source_d[15:8] = rx_byte;
				3'd2: source_d[7:0] = rx_byte;
				3'd3: destination_d[15:8] = rx_byte;
				3'd4: destination_d[7:0] = rx_byte;
				default: info_d = rx_byte;
			endcase
		end

		result = '0;
		if (in_header || in_payload) begin
			xor_next = xor_base ^ rx_byte;
			pos_next = pos + 5'd1;
		end else begin
			xor_next = 8'h00;
			pos_next = '0;
		end

		if (in_header) begin
			result.frame_status = btr_pkg::ST_HEADER;
		end else if (in_payload) begin
			result.frame_status  = btr_pkg::ST_PAYLOAD;
			result.payload_byte  = rx_byte;
			result.payload_index = payload_off[3:0];
		end else if (~xor_base == rx_byte) begin
			result.frame_status = btr_pkg::ST_ACCEPT;
		end else begin
			result.frame_status = btr_pkg::ST_LRCERR;
		end

		result.control_field       = control_d;
		result.source_address      = source_d;
		result.destination_address = destination_d;
		result.info_field          = info_d;
		result.payload_length      = {1'b0, info_d[3:0]} + 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			running_xor_q   <= '0;
			control_q       <= '0;
			source_q        <= '0;
			destination_q   <= '0;
			info_q          <= '0;
		end else if (take) begin
			byte_position_q <= pos_next;
			running_xor_q   <= xor_next;
			control_q       <= control_d;
			source_q        <= source_d;
			destination_q   <= destination_d;
			info_q          <= info_d;
		end
	end

`ifndef SYNTHESIS
	// The longest telegram is six header bytes, sixteen payload bytes and the check byte.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_position_q <= 5'd22)
		else $error("byte position beyond the check byte");

	a_check_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && !in_header && !in_payload |=> byte_position_q == '0 && running_xor_q == 8'h00)
		else $error("check byte did not end the telegram");

	a_payload_fits: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_payload |-> {1'b0, payload_off[3:0]} < result.payload_length)
		else $error("payload index past the payload length");
`endif

endmodule

[rtl/btr_out_reg.sv]
// ----------------------------------------------------------------------------
// btr_out_reg
// Result register toward the master side. It reloads in the same cycle
// that its word is taken, so a byte can be accepted every cycle while the master side takes each word.
// ----------------------------------------------------------------------------
module btr_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  btr_pkg::result_t result,
	output logic             free,
	output logic             valid,
	input  logic             taken,
	output btr_pkg::result_t held
);

	logic             valid_q;
	btr_pkg::result_t held_q;

	assign free  = !valid_q || taken;
	assign valid = valid_q;
	assign held  = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (taken) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			held_q <= result;
		end
	end

endmodule

[rtl/bus_telegram_receiver_lrc_unit.sv]
// ----------------------------------------------------------------------------
// bus_telegram_receiver_lrc_unit
// Building-bus telegram receiver with longitudinal check byte.
// ----------------------------------------------------------------------------
// The slave side takes one telegram byte per word; tuser high marks the
// control byte of a new telegram and drops any partial one. Bytes follow as
// control, source high/low, destination high/low, info, info[3:0]+1 payload
// bytes and a check byte, which must equal the complement of the XOR of all
// earlier bytes.
// Every byte yields exactly one word on the master side: tuser gives the
// status (header byte, payload byte, frame accepted, check error) and tdata
// the payload byte and index plus the captured header fields.
// The result word is registered and appears in the cycle after acceptance. Throughput is one
// byte per cycle; the single result register reloads in the cycle its word
// is taken. When the master side stalls, the held word stays and s_tready
// drops until it is taken.
// Reset clears the framing position, the running XOR and the captured
// header fields, and empties the result register.
// ----------------------------------------------------------------------------
module bus_telegram_receiver_lrc_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic        s_tuser,  // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] payload_byte, [11:8] payload_index, [19:12] control_field,
	// [35:20] source_address, [51:36] destination_address,
	// [59:52] info_field, [64:60] payload_length, [71:65] zero
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser   // [1:0] frame_status
);

	logic             take;
	logic             free;
	btr_pkg::result_t result;
	btr_pkg::result_t held;

	assign s_tready = free;
	assign take     = s_tvalid && free;

	btr_frame_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.rx_byte     (s_tdata),
		.frame_start (s_tuser),
		.result      (result)
	);

	btr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.result (result),
		.free   (free),
		.valid  (m_tvalid),
		.taken  (m_tready),
		.held   (held)
	);

	assign m_tuser = held.frame_status;
	assign m_tdata = {7'd0, held.payload_length, held.info_field,
		held.destination_address, held.source_address, held.control_field,
		held.payload_index, held.payload_byte};

`ifndef SYNTHESIS
	a_start_is_header: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> m_tvalid && m_tuser == btr_pkg::ST_HEADER)
		else $error("start byte not reported as a header byte");

	a_non_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != btr_pkg::ST_PAYLOAD |-> m_tdata[11:0] == 12'd0)
		else $error("payload fields set outside a payload byte");

	a_length_matches_info: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[64:60] == {1'b0, m_tdata[55:52]} + 5'd1)
		else $error("payload length does not follow the info byte");
`endif

endmodule
